### rtl/arfs_pkg.sv
// Shared types, codes and the control program of the alternating RGB fade sequencer.
package arfs_pkg;

  localparam int unsigned StepW   = 4;
  localparam int unsigned ProgLen = 11;

  typedef logic [StepW-1:0] step_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_SEGMENT_TICKS = 2'd0;
  localparam logic [1:0] REG_COLOR_A       = 2'd1;
  localparam logic [1:0] REG_COLOR_B       = 2'd2;

  // Command codes carried by a request.
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  // Color channel selects.
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef enum logic [1:0] {
    RUN_RUNNING = 2'd0,
    RUN_FADE    = 2'd1,
    RUN_LAST    = 2'd2,
    RUN_STOPPED = 2'd3
  } run_state_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_DRAW,
    OP_INC,
    OP_CH_CLEAR,
    OP_SHOW_TARGET,
    OP_MUL,
    OP_DIV_STEP,
    OP_CH_WRITE,
    OP_SEG_END,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_JUMP,
    C_NO_ACCEPT,
    C_STOPPED,
    C_PAUSED,
    C_WITHIN,
    C_CNT_MORE,
    C_CH_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  // Step addresses used as jump targets.
  localparam step_t STEP_WAIT    = 4'd0;
  localparam step_t STEP_MUL     = 4'd6;
  localparam step_t STEP_DIV     = 4'd7;
  localparam step_t STEP_SEG_END = 4'd9;
  localparam step_t STEP_EMIT    = 4'd10;
  localparam step_t STEP_LAST    = 4'd10;

  // A taken condition loads the target; otherwise the step counter advances.
  localparam ctrl_word_t Prog [ProgLen] = '{
    '{OP_ACCEPT,      C_NO_ACCEPT, STEP_WAIT},     // wait for a request
    '{OP_NOP,         C_STOPPED,   STEP_EMIT},     // stopped: nothing advances
    '{OP_DRAW,        C_PAUSED,    STEP_SEG_END},  // paused: hold color and time
    '{OP_INC,         C_NEXT,      STEP_WAIT},     // advance elapsed
    '{OP_CH_CLEAR,    C_WITHIN,    STEP_MUL},      // interpolate when in range
    '{OP_SHOW_TARGET, C_JUMP,      STEP_SEG_END},
    '{OP_MUL,         C_NEXT,      STEP_WAIT},     // |diff| * elapsed
    '{OP_DIV_STEP,    C_CNT_MORE,  STEP_DIV},      // eight quotient bits
    '{OP_CH_WRITE,    C_CH_MORE,   STEP_MUL},      // next channel
    '{OP_SEG_END,     C_NEXT,      STEP_WAIT},
    '{OP_EMIT,        C_OUT_BUSY,  STEP_EMIT}      // wraps to the wait step
  };

endpackage

### rtl/alternating_rgb_fade_sequencer_top.sv
// Alternating RGB fade sequencer: microcoded control over a shared multiply and divide datapath.
// Each input request is one frame tick and yields exactly one result. For a request that
// interpolates, a small microprogram runs three channels one after another through one
// 8x16 multiplier and one restoring divider that produces one quotient bit per cycle. The
// next request is taken in the cycle after the result is loaded into the output register,
// which holds it while the receiver stalls. Configuration writes take effect at once and
// are meant to be made while the block is idle; segment_ticks is sampled at each segment
// start.
module alternating_rgb_fade_sequencer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic        in_paused,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_drawing
);

  import arfs_pkg::*;

  // Configuration.
  logic [15:0] seg_ticks_r;
  logic [23:0] color_a_r;
  logic [23:0] color_b_r;

  // Sequencer and fade state.
  step_t       pc_r;
  run_state_t  run_state_r;
  logic        phase_r;
  logic [15:0] elapsed_r;
  logic [15:0] seg_len_r;
  logic [23:0] start_color_r;
  logic [23:0] target_color_r;
  logic [23:0] shown_color_r;
  logic        drawing_r;
  logic        out_valid_r;

  // Datapath.
  logic        paused_r;
  logic [1:0]  ch_r;
  logic [2:0]  div_cnt_r;
  logic [15:0] rem_r;
  logic [7:0]  quo_r;
  logic        neg_r;
  logic [7:0]  out_red_r;
  logic [7:0]  out_green_r;
  logic [7:0]  out_blue_r;
  logic        out_drawing_r;

  ctrl_word_t  ctrl;
  logic        in_acc;
  logic        out_free;
  logic        cond_true;
  step_t       pc_nxt;

  logic [7:0]  s_byte;
  logic [7:0]  t_byte;
  logic        diff_neg;
  logic [7:0]  mag;
  logic [23:0] prod;
  logic [16:0] trial;
  logic        trial_ge;
  logic [16:0] trial_sub;
  logic [15:0] rem_nxt;
  logic [7:0]  chan_res;
  logic [23:0] shown_upd;
  logic [15:0] seg_ticks_eff;
  logic        seg_done;

  assign ctrl     = Prog[pc_r];
  assign in_stall = (pc_r != STEP_WAIT);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    unique case (ctrl.cond)
      C_NEXT:      cond_true = 1'b0;
      C_JUMP:      cond_true = 1'b1;
      C_NO_ACCEPT: cond_true = !in_acc;
      C_STOPPED:   cond_true = (run_state_r == RUN_STOPPED);
      C_PAUSED:    cond_true = paused_r;
      C_WITHIN:    cond_true = (elapsed_r <= seg_len_r);
      C_CNT_MORE:  cond_true = (div_cnt_r != 3'd7);
      C_CH_MORE:   cond_true = (ch_r != CH_BLUE);
      C_OUT_BUSY:  cond_true = !out_free;
      default:     cond_true = 1'b0;
    endcase
    if (cond_true) begin
      pc_nxt = ctrl.target;
    end else if (pc_r == STEP_LAST) begin
      pc_nxt = STEP_WAIT;
    end else begin
      pc_nxt = pc_r + step_t'(1);
    end
  end

  // Channel operands of the current channel.
  always_comb begin
    unique case (ch_r)
      CH_RED: begin
        s_byte = start_color_r[23:16];
        t_byte = target_color_r[23:16];
      end
      CH_GREEN: begin
        s_byte = start_color_r[15:8];
        t_byte = target_color_r[15:8];
      end
      default: begin
        s_byte = start_color_r[7:0];
        t_byte = target_color_r[7:0];
      end
    endcase
  end

  // The divide works on the magnitude; truncation toward zero then follows from the sign.
  assign diff_neg  = (t_byte < s_byte);
  assign mag       = diff_neg ? (s_byte - t_byte) : (t_byte - s_byte);
  assign prod      = {16'd0, mag} * {8'd0, elapsed_r};

  assign trial     = {rem_r, quo_r[7]};
  assign trial_ge  = (trial >= {1'b0, seg_len_r});
  assign trial_sub = trial - {1'b0, seg_len_r};
  assign rem_nxt   = trial_ge ? trial_sub[15:0] : trial[15:0];

  assign chan_res  = neg_r ? (s_byte - quo_r) : (s_byte + quo_r);

  always_comb begin
    shown_upd = shown_color_r;
    unique case (ch_r)
      CH_RED:   shown_upd[23:16] = chan_res;
      CH_GREEN: shown_upd[15:8]  = chan_res;
      CH_BLUE:  shown_upd[7:0]   = chan_res;
      default:  shown_upd        = shown_color_r;
    endcase
  end

  assign seg_ticks_eff = (seg_ticks_r == 16'd0) ? 16'd1 : seg_ticks_r;
  assign seg_done      = (elapsed_r >= seg_len_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_ticks_r    <= 16'd64;
      color_a_r      <= 24'h000000;
      color_b_r      <= 24'hFF0000;
      pc_r           <= STEP_WAIT;
      run_state_r    <= RUN_FADE;
      phase_r        <= 1'b0;
      elapsed_r      <= 16'd0;
      seg_len_r      <= 16'd1;
      start_color_r  <= 24'd0;
      target_color_r <= 24'd0;
      shown_color_r  <= 24'd0;
      drawing_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SEGMENT_TICKS: seg_ticks_r <= cfg_wdata[15:0];
          REG_COLOR_A:       color_a_r   <= cfg_wdata;
          REG_COLOR_B:       color_b_r   <= cfg_wdata;
          default:           ;
        endcase
      end

      pc_r <= pc_nxt;

      if ((ctrl.op == OP_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (ctrl.op)
        OP_ACCEPT: begin
          if (in_acc) begin
            drawing_r <= 1'b0;
            if (in_mode == MODE_START) begin
              run_state_r <= RUN_RUNNING;
            end else if (in_mode == MODE_STOP) begin
              run_state_r <= RUN_FADE;
            end
          end
        end
        OP_DRAW:        drawing_r     <= 1'b1;
        OP_INC:         elapsed_r     <= elapsed_r + 16'd1;
        OP_SHOW_TARGET: shown_color_r <= target_color_r;
        OP_CH_WRITE:    shown_color_r <= shown_upd;
        OP_SEG_END: begin
          if (seg_done) begin
            elapsed_r     <= 16'd0;
            start_color_r <= target_color_r;
            if (run_state_r == RUN_FADE) begin
              target_color_r <= 24'd0;
            end else begin
              target_color_r <= phase_r ? color_b_r : color_a_r;
            end
            seg_len_r <= seg_ticks_eff;
            phase_r   <= !phase_r;
            if (run_state_r == RUN_LAST) begin
              run_state_r <= RUN_STOPPED;
            end else if (run_state_r == RUN_FADE) begin
              run_state_r <= RUN_LAST;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_ACCEPT: begin
        if (in_acc) begin
          paused_r <= in_paused;
        end
      end
      OP_CH_CLEAR: ch_r <= CH_RED;
      OP_MUL: begin
        // The quotient fits in eight bits, so the upper product bits start the remainder.
        rem_r     <= prod[23:8];
        quo_r     <= prod[7:0];
        neg_r     <= diff_neg;
        div_cnt_r <= 3'd0;
      end
      OP_DIV_STEP: begin
        rem_r     <= rem_nxt;
        quo_r     <= {quo_r[6:0], trial_ge};
        div_cnt_r <= div_cnt_r + 3'd1;
      end
      OP_CH_WRITE: ch_r <= ch_r + 2'd1;
      OP_EMIT: begin
        if (out_free) begin
          out_red_r     <= shown_color_r[23:16];
          out_green_r   <= shown_color_r[15:8];
          out_blue_r    <= shown_color_r[7:0];
          out_drawing_r <= drawing_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_red     = out_red_r;
  assign out_green   = out_green_r;
  assign out_blue    = out_blue_r;
  assign out_drawing = out_drawing_r;

endmodule
